// ===== sv/tca_pkg.sv =====
// ---------------------------------------------------------------------------
// Totalistic cellular automaton package
// Shared widths, codes and the command and status bundles between the
// sequencer and the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package tca_pkg;

  // Default sizes of the block.
  localparam int unsigned MaxCellsDef    = 64;
  localparam int unsigned MaxRadiusDef   = 4;
  localparam int unsigned RuleEntriesDef = 64;

  // Widths of the beat fields and of the configuration port.
  localparam int unsigned CmdW     = 2;
  localparam int unsigned IdxW     = 6;
  localparam int unsigned ValW     = 2;
  localparam int unsigned RadW     = 3;
  localparam int unsigned RowLenW  = 7;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 7;

  // Largest state a cell can hold.
  localparam int unsigned CellMax = (2 ** ValW) - 1;

  // Configuration values after reset.
  localparam logic [RadW-1:0]    RadiusRst = 3'd1;
  localparam logic [RowLenW-1:0] RowLenRst = 7'd64;

  // Input commands.
  typedef enum logic [CmdW-1:0] {
    CmdCellWr = 2'd0,
    CmdRuleWr = 2'd1,
    CmdStep   = 2'd2
  } cmd_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    RegRadius = 1'b0,
    RegRowLen = 1'b1
  } cfg_reg_e;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic in_fire;     // an input beat is taken this cycle
    logic start;       // begin a generation step
    logic seek;        // walk the read pointer back by one cell
    logic prime_init;  // load the window read count
    logic rd_issue;    // read the cell under the pointer and advance it
    logic rd_slide;    // the read slides the window rather than filling it
    logic rule_rd;     // look up the current sum in the rule table
    logic emit;        // load the output register and write the new cell
  } ctrl_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic cnt_zero;    // read or seek count exhausted
    logic is_last;     // the current cell is the last of the row
    logic out_free;    // the output register can take a beat
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== sv/tca_ram.sv =====
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module tca_ram #(
  parameter int unsigned Width = 2,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/tca_ctrl.sv =====
// ---------------------------------------------------------------------------
// Totalistic cellular automaton sequencer
// Takes command beats and steps the datapath through the seek, window fill
// and per-cell lookup and output phases of one generation.
// ---------------------------------------------------------------------------
`default_nettype none

module tca_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [tca_pkg::CmdW-1:0]   in_cmd_i,
  output logic                       in_ready_o,
  input  tca_pkg::dp_sts_t           sts_i,
  output tca_pkg::ctrl_cmd_t         cmd_o
);

  import tca_pkg::*;

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StSeek  = 6'b000010,
    StPrime = 6'b000100,
    StWait  = 6'b001000,
    StLook  = 6'b010000,
    StEmit  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   in_fire;

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;

  // Next state and datapath commands.
  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.in_fire  = in_fire;
    unique case (state_q)
      StIdle: begin
        if (in_fire && (in_cmd_i == CmdStep)) begin
          cmd_o.start = 1'b1;
          state_d     = StSeek;
        end
      end
      // Move the pointer to the left edge of the first window.
      StSeek: begin
        if (sts_i.cnt_zero) begin
          cmd_o.prime_init = 1'b1;
          state_d          = StPrime;
        end else begin
          cmd_o.seek = 1'b1;
        end
      end
      // Read the whole window of the first cell.
      StPrime: begin
        cmd_o.rd_issue = 1'b1;
        if (sts_i.cnt_zero) begin
          state_d = StWait;
        end
      end
      // The last window read returns here.
      StWait: begin
        state_d = StLook;
      end
      // Look up the sum and fetch the cell entering the next window.
      StLook: begin
        if (sts_i.out_free) begin
          cmd_o.rule_rd = 1'b1;
          if (!sts_i.is_last) begin
            cmd_o.rd_issue = 1'b1;
            cmd_o.rd_slide = 1'b1;
          end
          state_d = StEmit;
        end
      end
      StEmit: begin
        cmd_o.emit = 1'b1;
        state_d    = sts_i.is_last ? StIdle : StLook;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/tca_dp.sv =====
// ---------------------------------------------------------------------------
// Totalistic cellular automaton datapath
// Holds the configuration, the cell and rule memories, the sliding window
// with its running sum, and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module tca_dp #(
  parameter int unsigned MaxCells    = tca_pkg::MaxCellsDef,
  parameter int unsigned MaxRadius   = tca_pkg::MaxRadiusDef,
  parameter int unsigned RuleEntries = tca_pkg::RuleEntriesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tca_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tca_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic [tca_pkg::CmdW-1:0]     in_cmd_i,
  input  logic [tca_pkg::IdxW-1:0]     in_idx_i,
  input  logic [tca_pkg::ValW-1:0]     in_val_i,
  input  tca_pkg::ctrl_cmd_t           cmd_i,
  output tca_pkg::dp_sts_t             sts_o,
  output logic                         out_vld_o,
  input  logic                         out_rdy_i,
  output logic [tca_pkg::IdxW-1:0]     out_idx_o,
  output logic [tca_pkg::ValW-1:0]     out_val_o,
  output logic                         out_last_o
);

  import tca_pkg::*;

  localparam int unsigned CW  = $clog2(MaxCells);
  localparam int unsigned LW  = $clog2(MaxCells + 1);
  localparam int unsigned Win = 2 * MaxRadius + 1;
  localparam int unsigned WIW = $clog2(Win);
  localparam int unsigned SW  = $clog2(Win * CellMax + 1);
  localparam int unsigned RW  = $clog2(RuleEntries);

  // Configuration registers.
  logic [RadW-1:0]    rad_q;
  logic [RowLenW-1:0] rowlen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q    <= RadiusRst;
      rowlen_q <= RowLenRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        RegRadius: rad_q    <= cfg_wdata_i[RadW-1:0];
        RegRowLen: rowlen_q <= cfg_wdata_i[RowLenW-1:0];
        default:   rad_q    <= rad_q;
      endcase
    end
  end

  // Row length and radius in use, clamped to what the block holds.
  logic [LW-1:0]  len;
  logic [CW-1:0]  len_m1;
  logic [WIW-1:0] rad;
  logic [WIW-1:0] two_r;

  always_comb begin
    if (rowlen_q == '0) begin
      len = LW'(1);
    end else if (32'(rowlen_q) > 32'(MaxCells)) begin
      len = LW'(MaxCells);
    end else begin
      len = LW'(rowlen_q);
    end
    if (32'(rad_q) > 32'(MaxRadius)) begin
      rad = WIW'(MaxRadius);
    end else begin
      rad = WIW'(rad_q);
    end
  end

  assign len_m1 = CW'(len - LW'(1));
  assign two_r  = rad << 1;

  // Sequencing registers.
  logic [CW-1:0]  ptr_q;
  logic [CW-1:0]  cur_i_q;
  logic [WIW-1:0] cnt_q;
  logic [SW-1:0]  sum_q;
  logic [CW-1:0]  ptr_inc;
  logic [CW-1:0]  ptr_dec;

  assign ptr_inc = (ptr_q == len_m1) ? '0 : ptr_q + CW'(1);
  assign ptr_dec = (ptr_q == '0) ? len_m1 : ptr_q - CW'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      ptr_q   <= '0;
      cnt_q   <= rad;
      cur_i_q <= '0;
    end else begin
      if (cmd_i.seek) begin
        ptr_q <= ptr_dec;
        cnt_q <= cnt_q - WIW'(1);
      end else if (cmd_i.prime_init) begin
        cnt_q <= two_r;
      end else if (cmd_i.rd_issue) begin
        ptr_q <= ptr_inc;
        cnt_q <= cnt_q - WIW'(1);
      end
      if (cmd_i.emit) begin
        cur_i_q <= cur_i_q + CW'(1);
      end
    end
  end

  // Write decode for command beats.
  logic cell_wr_in;
  logic rule_wr;

  assign cell_wr_in = cmd_i.in_fire && (in_cmd_i == CmdCellWr) &&
                      (32'(in_idx_i) < 32'(len));
  assign rule_wr    = cmd_i.in_fire && (in_cmd_i == CmdRuleWr) &&
                      (32'(in_idx_i) < 32'(RuleEntries));

  // Rule table with valid bits standing in for the cleared contents.
  logic [ValW-1:0]        rule_rdata;
  logic [RuleEntries-1:0] rule_vld_q;
  logic [RW-1:0]          rule_raddr_q;
  logic                   rule_oor_q;
  logic [ValW-1:0]        rule_val;

  tca_ram #(
    .Width (ValW),
    .Depth (RuleEntries)
  ) u_rule_ram (
    .clk_i   (clk_i),
    .we_i    (rule_wr),
    .waddr_i (RW'(in_idx_i)),
    .wdata_i (in_val_i),
    .re_i    (cmd_i.rule_rd),
    .raddr_i (RW'(sum_q)),
    .rdata_o (rule_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rule_vld_q <= '0;
    end else if (rule_wr) begin
      rule_vld_q[RW'(in_idx_i)] <= 1'b1;
    end
  end

  // A sum beyond the table gives state zero.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rule_rd) begin
      rule_raddr_q <= RW'(sum_q);
      rule_oor_q   <= (32'(sum_q) >= 32'(RuleEntries));
    end
  end

  assign rule_val = rule_oor_q ? '0 : (rule_rdata & {ValW{rule_vld_q[rule_raddr_q]}});

  // Cell store, also with valid bits.
  logic                cell_we;
  logic [CW-1:0]       cell_waddr;
  logic [ValW-1:0]     cell_wdata;
  logic [ValW-1:0]     cell_rdata;
  logic [MaxCells-1:0] cell_vld_q;

  assign cell_we    = cell_wr_in || cmd_i.emit;
  assign cell_waddr = cmd_i.emit ? cur_i_q : CW'(in_idx_i);
  assign cell_wdata = cmd_i.emit ? rule_val : in_val_i;

  tca_ram #(
    .Width (ValW),
    .Depth (MaxCells)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (cell_we),
    .waddr_i (cell_waddr),
    .wdata_i (cell_wdata),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (ptr_q),
    .rdata_o (cell_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_vld_q <= '0;
    end else if (cell_we) begin
      cell_vld_q[cell_waddr] <= 1'b1;
    end
  end

  // Tracking of the cell read in flight. Cells below the current index have
  // already been replaced, so their old state comes from the save registers.
  logic            rd_vld_q;
  logic [CW-1:0]   pos_q;
  logic            from_save_q;
  logic            slide_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd_issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue) begin
      pos_q       <= ptr_q;
      from_save_q <= (ptr_q < cur_i_q);
      slide_q     <= cmd_i.rd_slide;
    end
  end

  // Old states of the lowest cells, needed again once the window wraps.
  logic [ValW-1:0] save_q [Win];
  logic [ValW-1:0] ret_val;
  logic            save_hit;

  assign ret_val  = from_save_q ? save_q[WIW'(pos_q)]
                                : (cell_rdata & {ValW{cell_vld_q[pos_q]}});
  assign save_hit = !from_save_q && (32'(pos_q) < 32'(Win));

  always_ff @(posedge clk_i) begin
    if (rd_vld_q && save_hit) begin
      save_q[WIW'(pos_q)] <= ret_val;
    end
  end

  // Window of old states; the oldest active entry leaves when it slides.
  logic [ValW-1:0] win_q [Win];
  logic [WIW-1:0]  tap_idx;
  logic [SW-1:0]   sum_d;

  assign tap_idx = WIW'(Win - 1) - two_r;
  assign sum_d   = sum_q + SW'(ret_val) - (slide_q ? SW'(win_q[tap_idx]) : '0);

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      for (int k = 0; k < Win - 1; k++) begin
        win_q[k] <= win_q[k+1];
      end
      win_q[Win-1] <= ret_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      sum_q <= '0;
    end else if (rd_vld_q) begin
      sum_q <= sum_d;
    end
  end

  // Output register.
  logic            out_vld_q;
  logic [IdxW-1:0] out_idx_q;
  logic [ValW-1:0] out_val_q;
  logic            out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_vld_q <= 1'b1;
    end else if (out_rdy_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_idx_q  <= IdxW'(cur_i_q);
      out_val_q  <= rule_val;
      out_last_q <= (cur_i_q == len_m1);
    end
  end

  assign out_vld_o  = out_vld_q;
  assign out_idx_o  = out_idx_q;
  assign out_val_o  = out_val_q;
  assign out_last_o = out_last_q;

  // Status to the sequencer.
  assign sts_o.cnt_zero = (cnt_q == '0);
  assign sts_o.is_last  = (cur_i_q == len_m1);
  assign sts_o.out_free = !out_vld_q || out_rdy_i;

endmodule

`default_nettype wire

// ===== sv/totalistic_ca_row_step.sv =====
// ---------------------------------------------------------------------------
// One-dimensional totalistic cellular automaton
// Circular row of four-state cells with a rule table indexed by the sum of
// each cell's neighbourhood; one generation per step command.
// ---------------------------------------------------------------------------
// Each input beat carries a command in tuser and an index and value in
// tdata. A step command makes the block read the cell memory to form the
// first window (it walks the pointer back to the left edge of the window,
// reads its 2r+1 cells and waits for the last read to return), then
// handles each cell in a look state for the registered rule table read
// and an emit state to load the output register. The cells are written
// back in place as they are produced. The cell store and the rule table
// read as zero after reset. The next command beat is taken once the last
// cell of a step has been loaded into the output register.
`default_nettype none

module totalistic_ca_row_step #(
  parameter int unsigned MaxCells    = tca_pkg::MaxCellsDef,
  parameter int unsigned MaxRadius   = tca_pkg::MaxRadiusDef,
  parameter int unsigned RuleEntries = tca_pkg::RuleEntriesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Command stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // [5:0] index, [7:6] value
  input  logic [tca_pkg::CmdW-1:0]     s_axis_tuser,   // [1:0] cmd
  // New row stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [7:0]                   m_axis_tdata,   // [5:0] cell_index, [7:6] cell_value
  output logic                         m_axis_tlast,
  // Configuration write port
  input  logic                         cfg_we_i,
  input  logic [tca_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tca_pkg::CfgDataW-1:0] cfg_wdata_i
);

  import tca_pkg::*;

  ctrl_cmd_t       cmd;
  dp_sts_t         sts;
  logic [IdxW-1:0] out_idx;
  logic [ValW-1:0] out_val;

  tca_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tca_dp #(
    .MaxCells    (MaxCells),
    .MaxRadius   (MaxRadius),
    .RuleEntries (RuleEntries)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_cmd_i    (s_axis_tuser),
    .in_idx_i    (s_axis_tdata[IdxW-1:0]),
    .in_val_i    (s_axis_tdata[IdxW+ValW-1:IdxW]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_vld_o   (m_axis_tvalid),
    .out_rdy_i   (m_axis_tready),
    .out_idx_o   (out_idx),
    .out_val_o   (out_val),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {out_val, out_idx};

endmodule

`default_nettype wire

// ===== sim/tb_totalistic_ca_row_step.sv =====
// ---------------------------------------------------------------------------
// Testbench for the totalistic cellular automaton row step
// Drives command beats and configuration writes into the block, predicts
// every cell of each new generation and checks the output stream beat by
// beat, under random sender and receiver idling and a long output stall.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_totalistic_ca_row_step;
  timeunit 1ns;
  timeprecision 1ps;

  import tca_pkg::*;

  // Command code that the block must ignore.
  localparam logic [CmdW-1:0] CmdUnused = 2'd3;

  localparam int unsigned NumPhases      = 12;
  localparam int unsigned ItemsPerPhase  = 35;
  localparam int unsigned HoldPhase      = 8;
  localparam int unsigned RxHoldCycles   = 400;
  // Settling margin after the longest step, at the largest radius and row.
  localparam int unsigned SettleCycles   = 3 * MaxRadiusDef + 3 + 2 * MaxCellsDef + 8;

  // One expected beat of the new row.
  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic [ValW-1:0] state;
    logic            last;
  } cell_beat_t;

  // Predicts each generation and checks the output beats against it.
  class ca_row_checker;
    logic [ValW-1:0]    cells [MaxCellsDef];
    logic [ValW-1:0]    rules [RuleEntriesDef];
    logic [RadW-1:0]    radius;
    logic [RowLenW-1:0] row_len;
    cell_beat_t         next_row_q [$];
    int unsigned        errors;

    function new();
      foreach (cells[i]) cells[i] = '0;
      foreach (rules[i]) rules[i] = '0;
      radius  = RadiusRst;
      row_len = RowLenRst;
      errors  = 0;
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      errors++;
    endtask

    function int unsigned eff_len();
      if (row_len == 0) return 1;
      if (row_len > MaxCellsDef) return MaxCellsDef;
      return row_len;
    endfunction

    function int unsigned eff_radius();
      if (radius > MaxRadiusDef) return MaxRadiusDef;
      return radius;
    endfunction

    function int unsigned pending();
      return next_row_q.size();
    endfunction

    function void set_config(cfg_reg_e sel, logic [CfgDataW-1:0] data);
      if (sel == RegRadius) begin
        radius = data[RadW-1:0];
      end else begin
        row_len = data[RowLenW-1:0];
      end
    endfunction

    // Computes the whole new row from the old one and queues its beats.
    function void advance_generation();
      int unsigned     len, r, acc, pos;
      logic [ValW-1:0] nxt [MaxCellsDef];
      cell_beat_t      beat;
      len = eff_len();
      r   = eff_radius();
      for (int unsigned i = 0; i < len; i++) begin
        acc = 0;
        for (int unsigned j = 0; j <= 2 * r; j++) begin
          pos = (i + len * r + j - r) % len;
          acc += cells[pos];
        end
        nxt[i] = (acc < RuleEntriesDef) ? rules[acc] : 2'd0;
      end
      for (int unsigned i = 0; i < len; i++) begin
        cells[i]   = nxt[i];
        beat.idx   = IdxW'(i);
        beat.state = nxt[i];
        beat.last  = (i == len - 1);
        next_row_q = {next_row_q, beat};
      end
    endfunction

    function void note_command(logic [CmdW-1:0] cmd, logic [IdxW-1:0] idx,
                               logic [ValW-1:0] val);
      if (cmd == CmdCellWr) begin
        if (idx < eff_len()) cells[idx] = val;
      end else if (cmd == CmdRuleWr) begin
        if (idx < RuleEntriesDef) rules[idx] = val;
      end else if (cmd == CmdStep) begin
        advance_generation();
      end
    endfunction

    task check_cell(logic [7:0] tdata, logic tlast);
      cell_beat_t want;
      if (next_row_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat: index %0d state %0d last %0b",
                                  tdata[5:0], tdata[7:6], tlast));
        return;
      end
      want = next_row_q.pop_front();
      if (tdata[5:0] !== want.idx)
        report_mismatch($sformatf("cell index %0d, expected %0d", tdata[5:0], want.idx));
      if (tdata[7:6] !== want.state)
        report_mismatch($sformatf("cell %0d state %0d, expected %0d",
                                  want.idx, tdata[7:6], want.state));
      if (tlast !== want.last)
        report_mismatch($sformatf("cell %0d last %0b, expected %0b",
                                  want.idx, tlast, want.last));
    endtask

    task flush_check();
      if (next_row_q.size() != 0)
        report_mismatch($sformatf("%0d expected cells never arrived", next_row_q.size()));
    endtask
  endclass

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata  = '0;   // [5:0] index, [7:6] value
  logic [CmdW-1:0]      s_axis_tuser  = '0;   // [1:0] cmd
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [7:0]           m_axis_tdata;         // [5:0] cell_index, [7:6] cell_value
  logic                 m_axis_tlast;
  logic                 cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i     = '0;
  logic [CfgDataW-1:0]  cfg_wdata_i   = '0;

  ca_row_checker chk;
  int          tx_idle_pct = 31;
  int          rx_idle_pct = 80;
  int          hold_req    = 0;
  int unsigned effective_items = 0;

  // Per-phase settings, the extremes among them.
  int unsigned phase_radius [NumPhases] = '{1, 2, 0, 4, 3, 1, 6, 2, 0, 4, 1, 7};
  int unsigned phase_len    [NumPhases] = '{8, 3, 2, 64, 12, 64, 5, 33, 64, 4, 100, 7};

  totalistic_ca_row_step dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Clock with a 20 ns period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Receiver: random back-pressure, or a long hold-off when one is requested.
  int hold_seen = 0;
  int hold_left = 0;
  always @(negedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = RxHoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Output monitor: every accepted beat is checked against the prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      chk.check_cell(m_axis_tdata, m_axis_tlast);
    end
  end

  // Offers one command beat after random idle cycles and waits for it to be taken.
  task automatic send_item(input logic [CmdW-1:0] cmd, input logic [IdxW-1:0] idx,
                           input logic [ValW-1:0] val);
    bit counts;
    counts = (cmd == CmdStep) || (cmd == CmdRuleWr) ||
             (cmd == CmdCellWr && idx < chk.eff_len());
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {val, idx};
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    chk.note_command(cmd, idx, val);
    if (counts) effective_items++;
  endtask

  // Writes one configuration register; only called while the block is idle.
  task automatic write_reg(input cfg_reg_e sel, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= sel;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    chk.set_config(sel, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Stops offering beats and waits until every expected cell has arrived.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (chk.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Main stimulus.
  initial begin
    int unsigned start, len, r, maxsum, n;
    chk = new();
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // After reset every cell and rule entry reads as zero.
    send_item(CmdStep, 6'd0, 2'd0);
    // An unknown command changes nothing.
    send_item(CmdUnused, 6'd63, 2'd3);
    send_item(CmdRuleWr, 6'd63, 2'd3);
    send_item(CmdRuleWr, 6'd0, 2'd1);
    send_item(CmdRuleWr, 6'd1, 2'd2);
    send_item(CmdRuleWr, 6'd3, 2'd3);
    send_item(CmdRuleWr, 6'd9, 2'd2);
    send_item(CmdCellWr, 6'd0, 2'd3);
    send_item(CmdCellWr, 6'd63, 2'd3);
    send_item(CmdCellWr, 6'd31, 2'd1);
    send_item(CmdStep, 6'd63, 2'd3);
    send_item(CmdStep, 6'd0, 2'd0);
    drain();

    // A row length of zero acts as one cell; writes beyond it are dropped.
    write_reg(RegRadius, 7'd0);
    write_reg(RegRowLen, 7'd0);
    send_item(CmdCellWr, 6'd1, 2'd2);
    send_item(CmdCellWr, 6'd0, 2'd2);
    send_item(CmdRuleWr, 6'd2, 2'd1);
    send_item(CmdStep, 6'd21, 2'd1);
    drain();

    // Radius above the maximum with a window far wider than the row.
    write_reg(RegRadius, 7'd7);
    write_reg(RegRowLen, 7'd1);
    send_item(CmdStep, 6'd42, 2'd2);
    send_item(CmdRuleWr, 6'd18, 2'd3);
    send_item(CmdStep, 6'd0, 2'd0);
    drain();

    // Largest radius, row length above the maximum; hidden cells come back.
    write_reg(RegRadius, 7'h7C);
    write_reg(RegRowLen, 7'd127);
    send_item(CmdCellWr, 6'd63, 2'd2);
    send_item(CmdStep, 6'd0, 2'd3);

    // Random phases, each under its own setting and idling regime.
    for (int p = 0; p < NumPhases; p++) begin
      drain();
      if (p < 4) begin
        tx_idle_pct = 31;
        rx_idle_pct = 80;
      end else if (p < 8) begin
        tx_idle_pct = 80;
        rx_idle_pct = 31;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      write_reg(RegRadius, {4'($urandom_range(0, 15)), 3'(phase_radius[p])});
      write_reg(RegRowLen, 7'(phase_len[p]));
      if (p == HoldPhase) begin
        @(posedge clk_i);
        hold_req++;
      end
      start  = effective_items;
      len    = chk.eff_len();
      r      = chk.eff_radius();
      maxsum = (2 * r + 1) * CellMax;
      if (maxsum > RuleEntriesDef - 1) maxsum = RuleEntriesDef - 1;
      while (effective_items - start < ItemsPerPhase) begin
        if ($urandom_range(0, 99) < 80) begin
          // Well-formed: a few cell and rule writes, then a step.
          n = $urandom_range(0, 4);
          repeat (n) begin
            send_item(CmdCellWr,
                      ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                                  : 6'($urandom_range(0, len - 1)),
                      2'($urandom_range(0, 3)));
          end
          n = $urandom_range(0, 3);
          repeat (n) begin
            send_item(CmdRuleWr,
                      ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                                  : 6'($urandom_range(0, maxsum)),
                      2'($urandom_range(0, 3)));
          end
          send_item(CmdStep, 6'($urandom_range(0, 63)), 2'($urandom_range(0, 3)));
        end else begin
          // Noise: any command with any index and value.
          send_item(2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
                    2'($urandom_range(0, 3)));
        end
      end
    end

    drain();
    chk.flush_check();
    if (chk.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
